>>> design/quadratic_probe_hash_table_unit_defines.svh
// ----------------------------------------------------------------------------
// quadratic probe hash table unit assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_PROBE_HASH_TABLE_UNIT_DEFINES_SVH
`define QUADRATIC_PROBE_HASH_TABLE_UNIT_DEFINES_SVH

// same-cycle implication
`define QPHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("qpht same-cycle check failed");

// next-cycle implication
`define QPHT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("qpht next-cycle check failed");

`endif

>>> design/qpht_pkg.sv
// ----------------------------------------------------------------------------
// qpht_pkg
// shared types and constants of the quadratic probe hash table unit
// ----------------------------------------------------------------------------
package qpht_pkg;

    // capacity is a power of two, so home slot and probe wrap are masks
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY) + 1;
    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int MARK_W   = 2;

    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    localparam logic [MARK_W-1:0] MARK_NEVER   = 2'd0;
    localparam logic [MARK_W-1:0] MARK_TAKEN   = 2'd1;
    localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [MARK_W-1:0] mark;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [CNT_W-1:0]    count_after;
        logic [VAL_W-1:0]    found_value;
        logic [STATUS_W-1:0] status;
    } t_result;

    localparam int RES_W       = $bits(t_result);
    localparam int IN_FIELDS_W = FUNC_W + KEY_W + VAL_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - RES_W;

endpackage

>>> design/quadratic_probe_hash_table_unit.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_unit
// open-addressing hash table with quadratic probing and deleted-slot marks
// ----------------------------------------------------------------------------
// an accepted item walks p probes (1..64), then commits and loads its result into the output reg
// items are taken one at a time; the walk reads one probe per cycle from the slot ram
// the probe walk stops at a matching key, a never-used slot or the 64th probe
// reset clears the slot valid bits and the entry count at once, no clearing pass
// a new item is taken while the previous result still waits in the output reg
module quadratic_probe_hash_table_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // func, key, insert_value
    input  logic [qpht_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // status, found_value, count_after
    output logic [qpht_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    logic                          rd_en;
    logic [qpht_pkg::ADDR_W-1:0]   rd_addr;
    qpht_pkg::t_entry              rd_data;
    logic                          wr_en;
    logic [qpht_pkg::ADDR_W-1:0]   wr_addr;
    qpht_pkg::t_entry              wr_data;
    logic                          res_valid;
    logic                          res_ready;
    qpht_pkg::t_result             res;

    qpht_ram #(
        .WIDTH (qpht_pkg::ENTRY_W),
        .DEPTH (qpht_pkg::CAPACITY)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    qpht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_func      (i_s_axis_tdata[qpht_pkg::FUNC_W-1:0]),
        .i_key       (i_s_axis_tdata[qpht_pkg::FUNC_W +: qpht_pkg::KEY_W]),
        .i_value     (i_s_axis_tdata[qpht_pkg::FUNC_W + qpht_pkg::KEY_W +: qpht_pkg::VAL_W]),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    qpht_out_reg u_out_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (res_valid),
        .o_load_ready    (res_ready),
        .i_res           (res),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

>>> design/qpht_ram.sv
// ----------------------------------------------------------------------------
// qpht_ram
// generic single-write, single-read synchronous ram with registered read
// ----------------------------------------------------------------------------
module qpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/qpht_out_reg.sv
// ----------------------------------------------------------------------------
// qpht_out_reg
// result holding register in front of the output stream
// ----------------------------------------------------------------------------
module qpht_out_reg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    output logic                                o_load_ready,
    input  qpht_pkg::t_result                   i_res,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [qpht_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    logic               r_valid;
    logic               n_valid;
    qpht_pkg::t_result  r_res;

    assign o_load_ready = !r_valid || i_m_axis_tready;

    always_comb begin
        n_valid = r_valid;
        if (i_load && o_load_ready) begin
            n_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_load_ready) begin
            r_res <= i_res;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {{qpht_pkg::OUT_PAD_W{1'b0}}, r_res};

endmodule

>>> design/qpht_ctrl.sv
// ----------------------------------------------------------------------------
// qpht_ctrl
// probe sequencer: walks the quadratic probe path, decides and writes back
// ----------------------------------------------------------------------------
module qpht_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [qpht_pkg::FUNC_W-1:0]        i_func,
    input  logic [qpht_pkg::KEY_W-1:0]         i_key,
    input  logic [qpht_pkg::VAL_W-1:0]         i_value,
    output logic                               o_rd_en,
    output logic [qpht_pkg::ADDR_W-1:0]        o_rd_addr,
    input  qpht_pkg::t_entry                   i_rd_data,
    output logic                               o_wr_en,
    output logic [qpht_pkg::ADDR_W-1:0]        o_wr_addr,
    output qpht_pkg::t_entry                   o_wr_data,
    output logic                               o_res_valid,
    input  logic                               i_res_ready,
    output qpht_pkg::t_result                  o_res
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_PROBE  = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state                              r_state;
    t_state                              n_state;
    logic [qpht_pkg::FUNC_W-1:0]         r_func;
    logic [qpht_pkg::KEY_W-1:0]          r_key;
    logic [qpht_pkg::VAL_W-1:0]          r_value;
    logic [qpht_pkg::ADDR_W-1:0]         r_home;
    logic [qpht_pkg::ADDR_W-1:0]         r_slot;
    logic [qpht_pkg::ADDR_W-1:0]         r_offset;
    logic [qpht_pkg::ADDR_W-1:0]         r_step;
    logic [qpht_pkg::ADDR_W-1:0]         r_probe;
    logic                                r_hit;
    logic [qpht_pkg::ADDR_W-1:0]         r_hit_slot;
    logic [qpht_pkg::VAL_W-1:0]          r_hit_value;
    logic                                r_have_free;
    logic [qpht_pkg::ADDR_W-1:0]         r_free_slot;
    logic [qpht_pkg::CAPACITY-1:0]       r_valid;
    logic [qpht_pkg::CNT_W-1:0]          r_count;
    logic [qpht_pkg::CNT_W-1:0]          n_count;

    logic                                accept;
    logic                                commit;
    logic [qpht_pkg::MARK_W-1:0]         mark;
    logic                                taken;
    logic                                match;
    logic                                stop;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign commit     = (r_state == S_COMMIT) && i_res_ready;

    // probe read: home slot on accept, then home plus i squared
    assign o_rd_en   = accept || (r_state == S_PROBE);
    assign o_rd_addr = (r_state == S_IDLE) ? i_key[qpht_pkg::ADDR_W-1:0]
                                           : r_home + r_offset;

    // slot whose data arrives this cycle
    assign mark  = r_valid[r_slot] ? i_rd_data.mark : qpht_pkg::MARK_NEVER;
    assign taken = (mark == qpht_pkg::MARK_TAKEN);
    assign match = taken && (i_rd_data.key == r_key);
    assign stop  = match || (mark == qpht_pkg::MARK_NEVER)
                   || (r_probe == qpht_pkg::ADDR_W'(qpht_pkg::CAPACITY - 1));

    always_comb begin
        n_count           = r_count;
        o_wr_en           = 1'b0;
        o_wr_addr         = r_hit_slot;
        o_wr_data.mark    = qpht_pkg::MARK_DELETED;
        o_wr_data.key     = r_key;
        o_wr_data.value   = r_hit_value;
        o_res.status      = qpht_pkg::ST_NOT_FOUND;
        o_res.found_value = '0;
        unique case (r_func)
            qpht_pkg::FUNC_LOOKUP: begin
                if (r_hit) begin
                    o_res.status      = qpht_pkg::ST_OK;
                    o_res.found_value = r_hit_value;
                end
            end
            qpht_pkg::FUNC_INSERT: begin
                if (r_hit) begin
                    o_res.status = qpht_pkg::ST_DUPLICATE;
                end else if (r_count >= qpht_pkg::CNT_W'(qpht_pkg::CAPACITY / 2)) begin
                    o_res.status = qpht_pkg::ST_FULL;
                end else if (r_have_free) begin
                    o_res.status    = qpht_pkg::ST_OK;
                    o_wr_en         = commit;
                    o_wr_addr       = r_free_slot;
                    o_wr_data.mark  = qpht_pkg::MARK_TAKEN;
                    o_wr_data.value = r_value;
                    n_count         = r_count + qpht_pkg::CNT_W'(1);
                end else begin
                    o_res.status = qpht_pkg::ST_FULL;
                end
            end
            qpht_pkg::FUNC_REMOVE: begin
                if (r_hit) begin
                    o_res.status      = qpht_pkg::ST_OK;
                    o_res.found_value = r_hit_value;
                    o_wr_en           = commit;
                    if (r_count != '0) begin
                        n_count = r_count - qpht_pkg::CNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
        o_res.count_after = n_count;
    end

    assign o_res_valid = (r_state == S_COMMIT);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept) n_state = S_PROBE;
            S_PROBE:  if (stop) n_state = S_COMMIT;
            S_COMMIT: if (i_res_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_count <= n_count;
                if (o_wr_en) begin
                    r_valid[o_wr_addr] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func      <= i_func;
            r_key       <= i_key;
            r_value     <= i_value;
            r_home      <= i_key[qpht_pkg::ADDR_W-1:0];
            r_slot      <= i_key[qpht_pkg::ADDR_W-1:0];
            r_offset    <= qpht_pkg::ADDR_W'(1);
            r_step      <= qpht_pkg::ADDR_W'(3);
            r_probe     <= '0;
            r_hit       <= 1'b0;
            r_have_free <= 1'b0;
        end else if (r_state == S_PROBE) begin
            r_slot   <= o_rd_addr;
            r_offset <= r_offset + r_step;
            r_step   <= r_step + qpht_pkg::ADDR_W'(2);
            r_probe  <= r_probe + qpht_pkg::ADDR_W'(1);
            if (!taken && !r_have_free) begin
                r_have_free <= 1'b1;
                r_free_slot <= r_slot;
            end
            if (stop) begin
                r_hit       <= match;
                r_hit_slot  <= r_slot;
                r_hit_value <= i_rd_data.value;
            end
        end
    end

endmodule

>>> design/qpht_checker.sv
// ----------------------------------------------------------------------------
// qpht_checker
// port-level checks of the quadratic probe hash table unit
// ----------------------------------------------------------------------------
`include "quadratic_probe_hash_table_unit_defines.svh"

module qpht_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    input  logic                               o_s_axis_tready,
    input  logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    input  logic [qpht_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    logic [qpht_pkg::STATUS_W-1:0] status;
    logic [qpht_pkg::VAL_W-1:0]    found_value;
    logic [qpht_pkg::CNT_W-1:0]    count_after;

    assign status      = o_m_axis_tdata[qpht_pkg::STATUS_W-1:0];
    assign found_value = o_m_axis_tdata[qpht_pkg::STATUS_W +: qpht_pkg::VAL_W];
    assign count_after = o_m_axis_tdata[qpht_pkg::STATUS_W + qpht_pkg::VAL_W +: qpht_pkg::CNT_W];

    `QPHT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))
    `QPHT_ASSERT_IMP(a_count_half, i_clk, i_rst_n, o_m_axis_tvalid, count_after <= qpht_pkg::CNT_W'(qpht_pkg::CAPACITY / 2))
    `QPHT_ASSERT_IMP(a_value_zero, i_clk, i_rst_n, o_m_axis_tvalid && (status != qpht_pkg::ST_OK), found_value == '0)
    `QPHT_ASSERT_NXT(a_one_at_time, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

endmodule

bind quadratic_probe_hash_table_unit qpht_checker u_qpht_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
